// ----- rtl/xraj_pkg.sv -----
package xraj_pkg;

	localparam int MAX_LEN   = 64;
	localparam int STEP_BITS = 32;
	localparam int STEP_W    = 32;

	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int K_W   = (STEP_BITS > 1) ? $clog2(STEP_BITS) : 1;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef logic [MAX_LEN-1:0] ring_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	typedef struct packed {
		ring_t ring;
		cnt_t  len;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic ring_t width_mask(input cnt_t n);
		width_mask = ~({MAX_LEN{1'b1}} << n);
	endfunction

endpackage

// ----- rtl/xraj_front.sv -----
module xraj_front import xraj_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic    light_in,
	input  logic    last_in,
	input  q_stat_t q_stat,
	output logic    push,
	output job_t    push_job
);

	ring_t ring_q;
	cnt_t  cnt_q;
	ring_t ring_nxt;
	cnt_t  len_nxt;
	logic  room;
	logic  accept;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign room     = (cnt_q < cnt_t'(MAX_LEN));

	always_comb begin
		ring_nxt = ring_q;
		len_nxt  = cnt_q;
		if (room) begin
			ring_nxt[cnt_q[IDX_W-1:0]] = light_in;
			len_nxt                    = cnt_q + cnt_t'(1);
		end
	end

	assign push          = accept && last_in;
	assign push_job.ring = ring_nxt;
	assign push_job.len  = len_nxt;

	always_ff @(posedge clk) begin
		if (accept) begin
			ring_q <= ring_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (last_in) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= len_nxt;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cnt_t'(MAX_LEN))
		else $error("load count beyond ring capacity");

	a_push_len: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_job.len != '0))
		else $error("empty ring closed");

endmodule

// ----- rtl/xraj_queue.sv -----
module xraj_queue import xraj_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    push_job,
	input  logic    pop,
	output job_t    head,
	output q_stat_t q_stat
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.empty = (cnt_q == '0);
	assign q_stat.full  = (cnt_q == QCNT_W'(QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!q_stat.full || pop))
		else $error("request pushed into full queue");

endmodule

// ----- rtl/xraj_back.sv -----
module xraj_back import xraj_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_count_we,
	input  logic [STEP_W-1:0] step_count,
	input  job_t              head,
	input  q_stat_t           q_stat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              light_out,
	output logic              last_out
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	localparam logic [K_W-1:0] K_LAST = K_W'(STEP_BITS - 1);

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	ring_t             v_q;
	cnt_t              n_q;
	cnt_t              d_q;
	logic [K_W-1:0]    k_q;
	cnt_t              idx_q;

	ring_t             rot;
	logic [CNT_W:0]    dd;
	cnt_t              d_nxt;
	logic              out_take;

	assign rot = ((v_q << d_q) | (v_q >> (n_q - d_q))) & width_mask(n_q);
	assign dd  = {d_q, 1'b0};
	assign d_nxt = (dd >= {1'b0, n_q}) ? CNT_W'(dd - {1'b0, n_q}) : CNT_W'(dd);

	assign pop       = (state_q == ST_IDLE) && !q_stat.empty;
	assign out_valid = (state_q == ST_EMIT);
	assign light_out = v_q[idx_q[IDX_W-1:0]];
	assign last_out  = (idx_q == n_q - cnt_t'(1));
	assign out_take  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (step_count_we) begin
			step_q <= step_count;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					v_q   <= head.ring & width_mask(head.len);
					n_q   <= head.len;
					d_q   <= (head.len > cnt_t'(1)) ? cnt_t'(1) : '0;
					k_q   <= '0;
					idx_q <= '0;
				end
			end
			ST_CALC: begin
				if (step_q[k_q]) begin
					v_q <= v_q ^ rot;
				end
				d_q <= d_nxt;
				k_q <= k_q + K_W'(1);
			end
			ST_EMIT: begin
				if (out_take) begin
					idx_q <= idx_q + cnt_t'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= (head.len > cnt_t'(1)) ? ST_CALC : ST_EMIT;
					end
				end
				ST_CALC: begin
					if (k_q == K_LAST) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_take && last_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_calc_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> ((n_q > cnt_t'(1)) && (d_q < n_q)))
		else $error("rotation state out of range");

	a_emit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (idx_q < n_q))
		else $error("emit index past ring length");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && last_out) |=> !out_valid)
		else $error("result after final bit without new request");

endmodule

// ----- rtl/xor_ring_automaton_jump.sv -----
// Input: one light bit per cycle while in_stall is low; in_stall rises only while both queued rings wait.
// Per ring: fetch from the queue, then a rotate-XOR step for each of the STEP_BITS (32) bits of step_count
// (none for a one-bit ring), then one result bit per cycle while out_stall is low, n bits in load order.
// Loading of the next ring overlaps output of the current one.
// Reset clears step_count, the load count, the queue and the output state.
// Stored ring contents are not cleared by reset.
module xor_ring_automaton_jump import xraj_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              light_in,
	input  logic              last_in,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              light_out,
	output logic              last_out,
	input  logic              step_count_we,
	input  logic [STEP_W-1:0] step_count
);

	logic    push;
	job_t    push_job;
	logic    pop;
	job_t    head;
	q_stat_t q_stat;

	xraj_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.light_in (light_in),
		.last_in  (last_in),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	xraj_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	xraj_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_count_we (step_count_we),
		.step_count    (step_count),
		.head          (head),
		.q_stat        (q_stat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.light_out     (light_out),
		.last_out      (last_out)
	);

endmodule

// ----- tb/xor_ring_automaton_jump_tb.sv -----
module xor_ring_automaton_jump_tb;
	import xraj_pkg::*;

	typedef struct packed {
		logic light;
		logic last;
	} lamp_t;

	class ring_scoreboard;
		logic [63:0]       ring;
		int unsigned       loaded;
		logic [STEP_W-1:0] steps;
		lamp_t             lamps_q[$];
		int                errors;

		function new();
			ring = '0;
			loaded = 0;
			steps = '0;
			errors = 0;
		endfunction

		function void set_steps(logic [STEP_W-1:0] v);
			steps = v;
		endfunction

		// advance the ring by steps: one rotate-XOR by 2^k mod n per set bit k
		function logic [63:0] jump(logic [63:0] v, int unsigned n);
			logic [63:0] mask;
			int unsigned d;
			mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
			v &= mask;
			if (n <= 1)
				return v;
			d = 1 % n;
			for (int k = 0; k < STEP_BITS; k++) begin
				if (steps[k]) begin
					if (d == 0)
						v = '0;
					else
						v ^= ((v << d) | (v >> (n - d))) & mask;
				end
				d = (d * 2) % n;
			end
			return v;
		endfunction

		function void note_request(logic light, logic last);
			lamp_t e;
			int unsigned n;
			logic [63:0] v;
			if (loaded < MAX_LEN) begin
				ring[loaded] = light;
				loaded++;
			end
			if (!last)
				return;
			n = loaded;
			loaded = 0;
			v = jump(ring, n);
			for (int i = 0; i < n; i++) begin
				e.light = v[i];
				e.last = (i == n - 1);
				lamps_q.push_back(e);
			end
		endfunction

		function void check_result(logic light, logic last);
			lamp_t e;
			if (lamps_q.size() == 0) begin
				$error("unexpected result: light_out %0b last_out %0b", light, last);
				errors++;
				return;
			end
			e = lamps_q.pop_front();
			if (light !== e.light) begin
				$error("light_out: expected %0b, got %0b", e.light, light);
				errors++;
			end
			if (last !== e.last) begin
				$error("last_out: expected %0b, got %0b", e.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return lamps_q.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              light_in;
	logic              last_in;
	logic              out_valid;
	logic              out_stall;
	logic              light_out;
	logic              last_out;
	logic              step_count_we;
	logic [STEP_W-1:0] step_count;

	ring_scoreboard book = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	xor_ring_automaton_jump dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.light_in     (light_in),
		.last_in      (last_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.light_out    (light_out),
		.last_out     (last_out),
		.step_count_we(step_count_we),
		.step_count   (step_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAIL xor_ring_automaton_jump");
		$finish;
	end

	// receiver: check, then pick the next stall
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				book.check_result(light_out, last_out);
			if (hold_req) begin
				hold_left = 400;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	task automatic send_bit(input logic light, input logic last);
		in_valid <= 1'b1;
		light_in <= light;
		last_in <= last;
		do @(posedge clk); while (in_stall);
		book.note_request(light, last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_ring(input logic [63:0] pattern, input int len);
		for (int i = 0; i < len; i++) begin
			logic b;
			if (i < 64)
				b = pattern[i];
			else
				b = 1'($urandom_range(1));
			send_bit(b, i == len - 1);
		end
	endtask

	task automatic send_rings(input int items, input int max_len);
		int count;
		int len;
		count = 0;
		while (count < items) begin
			if ($urandom_range(1))
				len = $urandom_range(3, 1);
			else
				len = $urandom_range(max_len, 1);
			send_ring({$urandom, $urandom}, len);
			count += len;
		end
	endtask

	// drain, let the back end settle, then write
	task automatic set_steps(input logic [STEP_W-1:0] v);
		in_valid <= 1'b0;
		while (book.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		step_count_we <= 1'b1;
		step_count <= v;
		@(posedge clk);
		step_count_we <= 1'b0;
		book.set_steps(v);
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		light_in <= 1'b0;
		last_in <= 1'b0;
		step_count_we <= 1'b0;
		step_count <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_steps('0);
		send_ring(64'h1, 1);
		send_ring(64'b101, 3);
		set_steps('1);
		send_ring(64'h0, 1);
		send_ring(64'h1, 1);
		send_ring(64'b01, 2);
		send_ring(64'b10110, 5);
		// rotation by zero: 4 mod 4 clears the ring
		set_steps(32'd4);
		send_ring(64'b1011, 4);
		set_steps(32'd1);
		send_ring(64'b110, 3);

		send_idle_pct = 21;
		recv_idle_pct = 55;
		set_steps($urandom);
		send_rings(12, 12);
		set_steps($urandom);
		send_rings(12, 12);

		send_idle_pct = 55;
		recv_idle_pct = 21;
		set_steps($urandom);
		send_rings(12, 12);
		set_steps(32'h8000_0000 | $urandom);
		send_rings(12, 12);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_steps($urandom);
		// hold off the receiver so queued rings back up into the input
		hold_req = 1'b1;
		send_rings(16, 3);
		set_steps($urandom);
		// overflow: bits past the cap and the closing bit are dropped
		send_ring({$urandom, $urandom}, 66);
		send_rings(10, 12);
		set_steps('1);
		send_rings(10, 12);

		in_valid <= 1'b0;
		while (book.pending() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (book.errors == 0)
			$display("PASS xor_ring_automaton_jump");
		else
			$display("FAIL xor_ring_automaton_jump");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/xraj_pkg.sv
rtl/xraj_front.sv
rtl/xraj_queue.sv
rtl/xraj_back.sv
rtl/xor_ring_automaton_jump.sv
tb/xor_ring_automaton_jump_tb.sv
